FILE: rtl/dafrag_pkg.sv
// ----------------------------------------------------------------------------
// dafrag_pkg
// shared types and constants of the depth / alpha fragment test block
// ----------------------------------------------------------------------------
`default_nettype none

package dafrag_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COORD_W = 12;
  localparam int DEPTH_W = 16;
  localparam int RGB_W   = 24;
  localparam int ALPHA_W = 8;
  localparam int PIX_W   = 8;
  localparam int OC_W    = 3;
  localparam int SURF_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [SURF_W-1:0] SURF_RESET = SURF_W'(256);

  typedef enum logic [OC_W-1:0] {
    OC_PASS    = 3'd0,
    OC_BOUNDS  = 3'd1,
    OC_DISCARD = 3'd2,
    OC_ALPHA   = 3'd3,
    OC_DEPTH   = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_TEST_EN = 3'd0,
    REG_EARLY_DEPTH   = 3'd1,
    REG_DEPTH_WR_OFF  = 3'd2,
    REG_COLOR_WR_OFF  = 3'd3,
    REG_ALPHA_TEST_EN = 3'd4,
    REG_ALPHA_THRESH  = 3'd5,
    REG_SURF_WIDTH    = 3'd6,
    REG_SURF_HEIGHT   = 3'd7
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic rd;       // read the depth word of the item
    logic commit;   // test, update depth, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dafrag_if.sv
// ----------------------------------------------------------------------------
// dafrag_if
// fragment channel and result channel with valid / ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dafrag_in_if
  import dafrag_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [COORD_W-1:0] frag_x;
  logic signed [COORD_W-1:0] frag_y;
  logic [DEPTH_W-1:0]        frag_depth;
  logic [RGB_W-1:0]          frag_rgb;
  logic [ALPHA_W-1:0]        frag_alpha;
  logic                      shader_discard;

  modport source (output valid, cmd, frag_x, frag_y, frag_depth, frag_rgb, frag_alpha,
                  shader_discard, input ready);
  modport sink   (input valid, cmd, frag_x, frag_y, frag_depth, frag_rgb, frag_alpha,
                  shader_discard, output ready);
endinterface

interface dafrag_out_if
  import dafrag_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               write_color;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [RGB_W-1:0]   pixel_rgb;
  logic [ALPHA_W-1:0] pixel_alpha;
  logic [OC_W-1:0]    outcome;

  modport source (output valid, write_color, pixel_x, pixel_y, pixel_rgb, pixel_alpha,
                  outcome, input ready);
  modport sink   (input valid, write_color, pixel_x, pixel_y, pixel_rgb, pixel_alpha,
                  outcome, output ready);
endinterface

`default_nettype wire

FILE: rtl/dafrag_ram.sv
// ----------------------------------------------------------------------------
// dafrag_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dafrag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dafrag_ctrl.sv
// ----------------------------------------------------------------------------
// dafrag_ctrl
// sequencer: accept item, read depth word, test and commit result
// ----------------------------------------------------------------------------
`default_nettype none

module dafrag_ctrl
  import dafrag_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_comb begin
    cmd.capture = in_valid && in_ready_r;
    cmd.rd      = (state_r == S_READ);
    cmd.commit  = (state_r == S_EVAL) && stat.out_free;
  end

  // no item is taken while reset is held
  assign in_ready = in_ready_r && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_READ;
            in_ready_r <= 1'b0;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          // hold until the result register is free
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dafrag_dp.sv
// ----------------------------------------------------------------------------
// dafrag_dp
// datapath: config registers, item latch, depth store, tests, result register
// ----------------------------------------------------------------------------
`default_nettype none

module dafrag_dp
  import dafrag_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
  // item payload
  input  wire logic                      in_cmd,
  input  wire logic signed [COORD_W-1:0] in_frag_x,
  input  wire logic signed [COORD_W-1:0] in_frag_y,
  input  wire logic [DEPTH_W-1:0]        in_frag_depth,
  input  wire logic [RGB_W-1:0]          in_frag_rgb,
  input  wire logic [ALPHA_W-1:0]        in_frag_alpha,
  input  wire logic                      in_shader_discard,
  // result
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_write_color,
  output logic [PIX_W-1:0]               out_pixel_x,
  output logic [PIX_W-1:0]               out_pixel_y,
  output logic [RGB_W-1:0]               out_pixel_rgb,
  output logic [ALPHA_W-1:0]             out_pixel_alpha,
  output logic [OC_W-1:0]                out_outcome,
  // control
  input  wire dp_cmd_t                   cmd,
  output dp_stat_t                       stat
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int LIM_W = COORD_W + 1;
  localparam logic [LIM_W-1:0] MAX_W_LIM = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] MAX_H_LIM = LIM_W'(MAX_HEIGHT);

  // configuration registers
  logic                 dte_r, early_r, dwo_r, cwo_r, ate_r;
  logic [ALPHA_W-1:0]   thr_r;
  logic [SURF_W-1:0]    sw_r, sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dte_r   <= 1'b0;
      early_r <= 1'b0;
      dwo_r   <= 1'b0;
      cwo_r   <= 1'b0;
      ate_r   <= 1'b0;
      thr_r   <= '0;
      sw_r    <= SURF_RESET;
      sh_r    <= SURF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEPTH_TEST_EN: dte_r   <= cfg_wdata[0];
        REG_EARLY_DEPTH:   early_r <= cfg_wdata[0];
        REG_DEPTH_WR_OFF:  dwo_r   <= cfg_wdata[0];
        REG_COLOR_WR_OFF:  cwo_r   <= cfg_wdata[0];
        REG_ALPHA_TEST_EN: ate_r   <= cfg_wdata[0];
        REG_ALPHA_THRESH:  thr_r   <= cfg_wdata[ALPHA_W-1:0];
        REG_SURF_WIDTH:    sw_r    <= cfg_wdata[SURF_W-1:0];
        REG_SURF_HEIGHT:   sh_r    <= cfg_wdata[SURF_W-1:0];
        default: ;
      endcase
    end
  end

  // surface limits clamped to the store size
  logic [LIM_W-1:0] w_ext, h_ext, w_lim, h_lim;
  logic             in_bounds;

  always_comb begin
    w_ext = LIM_W'(sw_r);
    h_ext = LIM_W'(sh_r);
    w_lim = (w_ext > MAX_W_LIM) ? MAX_W_LIM : w_ext;
    h_lim = (h_ext > MAX_H_LIM) ? MAX_H_LIM : h_ext;
    in_bounds = !in_frag_x[COORD_W-1] && !in_frag_y[COORD_W-1] &&
                ({1'b0, in_frag_x} < w_lim) && ({1'b0, in_frag_y} < h_lim);
  end

  // item latch
  logic                      cmd_r, disc_r, inb_r;
  logic [COORD_W-1:0]        x_r, y_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic [RGB_W-1:0]          rgb_r;
  logic [ALPHA_W-1:0]        alpha_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      x_r     <= in_frag_x;
      y_r     <= in_frag_y;
      depth_r <= in_frag_depth;
      rgb_r   <= in_frag_rgb;
      alpha_r <= in_frag_alpha;
      disc_r  <= in_shader_discard;
      inb_r   <= in_bounds;
    end
  end

  // depth store
  logic [AW-1:0]      addr;
  logic [DEPTH_W-1:0] stored;
  logic               st_we;

  assign addr = {y_r[YW-1:0], x_r[XW-1:0]};

  dafrag_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (2 ** AW)
  ) u_depth_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (addr),
    .wdata (depth_r),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (stored)
  );

  // test chain
  outcome_t oc;
  logic     upd, le, early_t, late_t, color;

  always_comb begin
    le      = (depth_r <= stored);
    early_t = dte_r && early_r;
    late_t  = dte_r && !early_r;
    oc      = OC_PASS;
    upd     = 1'b0;
    if (!inb_r) begin
      oc = OC_BOUNDS;
    end else if (cmd_r) begin
      upd = 1'b1;
    end else begin
      if (early_t) begin
        if (le) begin
          upd = !dwo_r;
        end else begin
          oc = OC_DEPTH;
        end
      end
      if (oc == OC_PASS && disc_r) begin
        oc = OC_DISCARD;
      end else if (oc == OC_PASS && ate_r && (alpha_r < thr_r)) begin
        oc = OC_ALPHA;
      end else if (oc == OC_PASS && late_t) begin
        if (le) begin
          upd = !dwo_r;
        end else begin
          oc = OC_DEPTH;
        end
      end
    end
    color = inb_r && !cmd_r && (oc == OC_PASS) && !cwo_r;
    st_we = cmd.commit && upd;
  end

  // result register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_write_color <= color;
      out_pixel_x     <= color ? x_r[PIX_W-1:0] : '0;
      out_pixel_y     <= color ? y_r[PIX_W-1:0] : '0;
      out_pixel_rgb   <= color ? rgb_r : '0;
      out_pixel_alpha <= color ? alpha_r : '0;
      out_outcome     <= oc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/depth_alpha_fragment_test_top.sv
// ----------------------------------------------------------------------------
// depth_alpha_fragment_test_top
// per-fragment bounds, discard, alpha and depth test with its own depth store
// ----------------------------------------------------------------------------
// Each item on the input channel is either a fragment (cmd 0) or a depth load
// (cmd 1, used by software to clear the depth store) and yields exactly one
// result item. Each item goes through accept, depth store read, then test
// and commit; the registered read of the depth ram followed by the
// read-modify-write of the same word sets this order. The result register
// decouples the two channels, so the next item is accepted while a result
// still waits for out_ch.ready; the commit stage holds only if that register
// is still full. The depth store holds MAX_WIDTH x MAX_HEIGHT 16-bit words
// (rounded up to powers of two), has no reset and must be loaded before a
// fragment tests against a word. Configuration is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_alpha_fragment_test_top
  import dafrag_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // fragment / load items in
  dafrag_in_if.sink                  in_ch,
  // result items out
  dafrag_out_if.source               out_ch
);

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: owns in_ch.ready and the order of the work
  dafrag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // datapath: config, item latch, depth ram, tests and result register
  dafrag_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_ch.cmd),
    .in_frag_x         (in_ch.frag_x),
    .in_frag_y         (in_ch.frag_y),
    .in_frag_depth     (in_ch.frag_depth),
    .in_frag_rgb       (in_ch.frag_rgb),
    .in_frag_alpha     (in_ch.frag_alpha),
    .in_shader_discard (in_ch.shader_discard),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_write_color   (out_ch.write_color),
    .out_pixel_x       (out_ch.pixel_x),
    .out_pixel_y       (out_ch.pixel_y),
    .out_pixel_rgb     (out_ch.pixel_rgb),
    .out_pixel_alpha   (out_ch.pixel_alpha),
    .out_outcome       (out_ch.outcome),
    .cmd               (dp_cmd),
    .stat              (dp_stat)
  );

endmodule

`default_nettype wire

FILE: rtl/dafrag_chk.sv
// ----------------------------------------------------------------------------
// dafrag_chk
// port level checks of the fragment test block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dafrag_chk
  import dafrag_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               write_color,
  input wire logic [PIX_W-1:0]   pixel_x,
  input wire logic [PIX_W-1:0]   pixel_y,
  input wire logic [RGB_W-1:0]   pixel_rgb,
  input wire logic [ALPHA_W-1:0] pixel_alpha,
  input wire logic [OC_W-1:0]    outcome
);

  // items accepted and not yet delivered
  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(write_color))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  a_color_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && write_color |-> outcome == OC_PASS)
    else $error("colour write on a failed item");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_color |->
      pixel_x == '0 && pixel_y == '0 && pixel_rgb == '0 && pixel_alpha == '0)
    else $error("pixel fields set without colour write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item taken while previous one in work");

endmodule

bind depth_alpha_fragment_test_top dafrag_chk u_dafrag_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .write_color (out_ch.write_color),
  .pixel_x     (out_ch.pixel_x),
  .pixel_y     (out_ch.pixel_y),
  .pixel_rgb   (out_ch.pixel_rgb),
  .pixel_alpha (out_ch.pixel_alpha),
  .outcome     (out_ch.outcome)
);

`default_nettype wire

FILE: tb/raster_ops_checker.sv
// ----------------------------------------------------------------------------
// raster_ops_checker
// watches the fragment and result channels, predicts each result from its own
// copy of the configuration and depth store, and compares in arrival order
// ----------------------------------------------------------------------------

module raster_ops_checker
  import dafrag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  dafrag_in_if                  in_ch,
  dafrag_out_if                 out_ch,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               write_color;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [RGB_W-1:0]   pixel_rgb;
    logic [ALPHA_W-1:0] pixel_alpha;
    outcome_t           outcome;
  } pixel_write_t;

  localparam int STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  logic [DEPTH_W-1:0] depth_mirror [STORE_WORDS];
  pixel_write_t       results_due [$];

  logic               depth_test_on;
  logic               early_depth_on;
  logic               depth_wr_masked;
  logic               color_wr_masked;
  logic               alpha_test_on;
  logic [ALPHA_W-1:0] alpha_ref;
  logic [SURF_W-1:0]  surf_w;
  logic [SURF_W-1:0]  surf_h;

  // less-or-equal test, stores the new depth on a pass unless masked
  function automatic bit depth_passes(int unsigned addr, logic [DEPTH_W-1:0] z);
    if (z > depth_mirror[addr]) return 1'b0;
    if (!depth_wr_masked) depth_mirror[addr] = z;
    return 1'b1;
  endfunction

  function automatic pixel_write_t raster_ops(logic cmd, logic signed [COORD_W-1:0] fx,
                                              logic signed [COORD_W-1:0] fy,
                                              logic [DEPTH_W-1:0] z, logic [RGB_W-1:0] rgb,
                                              logic [ALPHA_W-1:0] a, logic disc);
    pixel_write_t r;
    int           cols;
    int           rows;
    int unsigned  addr;
    outcome_t     oc;
    r    = '0;
    cols = (surf_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(surf_w);
    rows = (surf_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(surf_h);
    if (fx < 0 || fy < 0 || int'(fx) >= cols || int'(fy) >= rows) begin
      r.outcome = OC_BOUNDS;
      return r;
    end
    addr = int'(fy) * DEF_MAX_WIDTH + int'(fx);
    if (cmd) begin
      depth_mirror[addr] = z;
      r.outcome = OC_PASS;
      return r;
    end
    oc = OC_PASS;
    if (depth_test_on && early_depth_on && !depth_passes(addr, z)) oc = OC_DEPTH;
    if (oc == OC_PASS && disc) oc = OC_DISCARD;
    if (oc == OC_PASS && alpha_test_on && a < alpha_ref) oc = OC_ALPHA;
    if (oc == OC_PASS && depth_test_on && !early_depth_on && !depth_passes(addr, z))
      oc = OC_DEPTH;
    if (oc == OC_PASS && !color_wr_masked) begin
      r.write_color = 1'b1;
      r.pixel_x     = fx[PIX_W-1:0];
      r.pixel_y     = fy[PIX_W-1:0];
      r.pixel_rgb   = rgb;
      r.pixel_alpha = a;
    end
    r.outcome = oc;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    pixel_write_t due;
    if (!rst_n) begin
      depth_test_on   = 1'b0;
      early_depth_on  = 1'b0;
      depth_wr_masked = 1'b0;
      color_wr_masked = 1'b0;
      alpha_test_on   = 1'b0;
      alpha_ref       = '0;
      surf_w          = SURF_RESET;
      surf_h          = SURF_RESET;
      fail_count      = 0;
      results_due.delete();
      pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result item with nothing expected, outcome 0x%0h",
                   $time, out_ch.outcome);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("write_color", 32'(want.write_color), 32'(out_ch.write_color));
          check_field("pixel_x", 32'(want.pixel_x), 32'(out_ch.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(out_ch.pixel_y));
          check_field("pixel_rgb", 32'(want.pixel_rgb), 32'(out_ch.pixel_rgb));
          check_field("pixel_alpha", 32'(want.pixel_alpha), 32'(out_ch.pixel_alpha));
          check_field("outcome", 32'(want.outcome), 32'(out_ch.outcome));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_DEPTH_TEST_EN: depth_test_on   = cfg_wdata[0];
          REG_EARLY_DEPTH:   early_depth_on  = cfg_wdata[0];
          REG_DEPTH_WR_OFF:  depth_wr_masked = cfg_wdata[0];
          REG_COLOR_WR_OFF:  color_wr_masked = cfg_wdata[0];
          REG_ALPHA_TEST_EN: alpha_test_on   = cfg_wdata[0];
          REG_ALPHA_THRESH:  alpha_ref       = cfg_wdata[ALPHA_W-1:0];
          REG_SURF_WIDTH:    surf_w          = cfg_wdata[SURF_W-1:0];
          REG_SURF_HEIGHT:   surf_h          = cfg_wdata[SURF_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        due = raster_ops(in_ch.cmd, in_ch.frag_x, in_ch.frag_y,
                         in_ch.frag_depth, in_ch.frag_rgb,
                         in_ch.frag_alpha, in_ch.shader_discard);
        results_due = {results_due, due};
      end
      pending <= results_due.size();
    end
  end

endmodule

FILE: tb/depth_alpha_fragment_test_top_tb.sv
// ----------------------------------------------------------------------------
// depth_alpha_fragment_test_top_tb
// drives fragments, depth loads and configuration into the depth / alpha
// fragment test block; a checker beside it predicts and compares every result
// ----------------------------------------------------------------------------

module depth_alpha_fragment_test_top_tb;
  import dafrag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_FRAG = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_CYCLES     = 200;
  localparam int STORE_WORDS     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dafrag_in_if  in_ch ();
  dafrag_out_if out_ch ();

  int fail_count;
  int pending;

  // idle chances in percent, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  // asks the receiver for one long hold-off
  bit hold_req = 1'b0;

  // stimulus-side view of the surface, so in-bounds fragments only hit
  // depth words that were loaded before
  int          surf_cols = DEF_MAX_WIDTH;
  int          surf_rows = DEF_MAX_HEIGHT;
  bit          loaded [STORE_WORDS];
  int unsigned loaded_q [$];

  depth_alpha_fragment_test_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  raster_ops_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("depth_alpha_fragment_test_top_tb: done, errors");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic bit on_surface(logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y);
    return x >= 0 && y >= 0 && int'(x) < surf_cols && int'(y) < surf_rows;
  endfunction

  // stop offering items and wait until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  // writes every register; only called while the block is idle
  task automatic set_config(int de, int early, int dwo, int cwo, int ate, int thr,
                            int w, int h);
    write_reg(REG_DEPTH_TEST_EN, de);
    write_reg(REG_EARLY_DEPTH, early);
    write_reg(REG_DEPTH_WR_OFF, dwo);
    write_reg(REG_COLOR_WR_OFF, cwo);
    write_reg(REG_ALPHA_TEST_EN, ate);
    write_reg(REG_ALPHA_THRESH, thr);
    write_reg(REG_SURF_WIDTH, w);
    write_reg(REG_SURF_HEIGHT, h);
    cfg_we    <= 1'b0;
    // sizes beyond the store act as clamped
    surf_cols = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    surf_rows = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
  endtask

  // one item on the fragment channel, with a random gap in front of it
  task automatic send_item(logic cmd, int x, int y, logic [DEPTH_W-1:0] z,
                           logic [RGB_W-1:0] rgb, logic [ALPHA_W-1:0] a, logic disc);
    int unsigned addr;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.frag_x         <= COORD_W'(x);
    in_ch.frag_y         <= COORD_W'(y);
    in_ch.frag_depth     <= z;
    in_ch.frag_rgb       <= rgb;
    in_ch.frag_alpha     <= a;
    in_ch.shader_discard <= disc;
    do @(posedge clk); while (!in_ch.ready);
    // a load inside the surface makes that depth word safe to test against
    if (cmd == CMD_LOAD && on_surface(COORD_W'(x), COORD_W'(y))) begin
      addr = y * DEF_MAX_WIDTH + x;
      if (!loaded[addr]) loaded_q = {loaded_q, addr};
      loaded[addr] = 1'b1;
    end
  endtask

  function automatic int pick_size();
    case ($urandom_range(15))
      0:       return 0;
      1:       return 1;
      2:       return 511;
      3:       return 257 + $urandom_range(253);
      4:       return 255;
      5, 6, 7: return $urandom_range(256, 1);
      default: return DEF_MAX_WIDTH;
    endcase
  endfunction

  task automatic random_config();
    int thr;
    case ($urandom_range(3))
      0:       thr = 0;
      1:       thr = 255;
      default: thr = $urandom_range(255);
    endcase
    set_config(int'($urandom_range(9) < 7), int'($urandom_range(1)),
               int'($urandom_range(3) == 0), int'($urandom_range(4) == 0),
               int'($urandom_range(1)), thr, pick_size(), pick_size());
  endtask

  task automatic random_item();
    int                        kind;
    int                        lim;
    int unsigned               pick;
    bit                        found;
    logic                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
    logic [ALPHA_W-1:0]        a;
    kind = $urandom_range(99);
    cmd  = CMD_FRAG;
    // default position: anywhere in the coordinate range
    x    = COORD_W'($urandom);
    y    = COORD_W'($urandom);
    if (kind < 20) begin
      // depth load, mostly into a small corner window so fragments overlap
      cmd = CMD_LOAD;
      if (surf_cols > 0 && surf_rows > 0 && $urandom_range(9) != 0) begin
        lim = ($urandom_range(3) == 0 || surf_cols < 16) ? surf_cols : 16;
        x   = COORD_W'($urandom_range(lim - 1));
        lim = ($urandom_range(3) == 0 || surf_rows < 16) ? surf_rows : 16;
        y   = COORD_W'($urandom_range(lim - 1));
      end
    end else if (kind < 88) begin
      // fragment on an already loaded pixel inside the current surface
      found = 1'b0;
      for (int t = 0; t < 8 && !found && loaded_q.size() > 0; t++) begin
        pick  = loaded_q[$urandom_range(loaded_q.size() - 1)];
        x     = COORD_W'(pick % DEF_MAX_WIDTH);
        y     = COORD_W'(pick / DEF_MAX_WIDTH);
        found = on_surface(x, y);
      end
      if (!found) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end
    end else if (kind < 94) begin
      // just past an edge of the surface
      x = COORD_W'($urandom_range(15));
      y = COORD_W'($urandom_range(15));
      case ($urandom_range(3))
        0:       x = COORD_W'(surf_cols);
        1:       y = COORD_W'(surf_rows);
        2:       x = '1;
        default: y = '1;
      endcase
    end
    // never test against a depth word nobody wrote: turn it into a load
    if (cmd == CMD_FRAG && on_surface(x, y) && !loaded[int'(y) * DEF_MAX_WIDTH + int'(x)])
      cmd = CMD_LOAD;
    case ($urandom_range(9))
      0:       z = '0;
      1:       z = '1;
      2, 3:    z = DEPTH_W'($urandom_range(16'h0fff));
      default: z = DEPTH_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       a = '0;
      1:       a = '1;
      default: a = ALPHA_W'($urandom);
    endcase
    send_item(cmd, int'(x), int'(y), z, RGB_W'($urandom), a, $urandom_range(4) == 0);
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_FRAG;
    in_ch.frag_x         = '0;
    in_ch.frag_y         = '0;
    in_ch.frag_depth     = '0;
    in_ch.frag_rgb       = '0;
    in_ch.frag_alpha     = '0;
    in_ch.shader_discard = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_DEPTH_TEST_EN;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    send_idle_pct        = 13;
    recv_idle_pct        = 83;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset configuration first ----
    // seed a few depth words, corners included
    send_item(CMD_LOAD, 0, 0, 16'h8000, '0, '0, 1'b0);
    send_item(CMD_LOAD, 1, 0, 16'hffff, '0, '0, 1'b0);
    send_item(CMD_LOAD, 255, 255, 16'h0000, '0, '0, 1'b0);
    send_item(CMD_LOAD, 255, 0, 16'h00ff, '0, '0, 1'b0);
    // load off the surface is dropped and reports out of bounds
    send_item(CMD_LOAD, -1, 0, 16'h1234, '0, '0, 1'b0);
    // depth test off: plain pass with all-ones color and alpha, then a discard
    send_item(CMD_FRAG, 0, 0, 16'hffff, 24'hffffff, 8'hff, 1'b0);
    send_item(CMD_FRAG, 255, 255, 16'h0000, '0, '0, 1'b1);
    // bounds wins over discard, then the coordinate extremes
    send_item(CMD_FRAG, 256, 0, 16'h0000, 24'h123456, 8'h80, 1'b1);
    send_item(CMD_FRAG, -2048, 2047, 16'h0000, '1, '1, 1'b0);
    send_item(CMD_FRAG, 2047, -2048, 16'hffff, '1, '1, 1'b0);
    send_item(CMD_FRAG, 0, 256, 16'h0000, '1, '1, 1'b0);

    // late depth test with alpha threshold
    drain();
    set_config(1, 0, 0, 0, 1, 128, 256, 256);
    send_item(CMD_FRAG, 0, 0, 16'h8000, 24'habcdef, 8'd128, 1'b0);  // equal depth passes
    send_item(CMD_FRAG, 0, 0, 16'h8001, 24'habcdef, 8'd255, 1'b0);  // farther fails
    send_item(CMD_FRAG, 0, 0, 16'h0000, 24'habcdef, 8'd127, 1'b0);  // alpha just below
    send_item(CMD_FRAG, 1, 0, 16'hffff, 24'h00ff00, 8'd200, 1'b0);

    // early depth: the update survives a later discard; color masked
    drain();
    set_config(1, 1, 0, 1, 1, 255, 256, 256);
    send_item(CMD_FRAG, 1, 0, 16'h1000, 24'h0000ff, 8'd0, 1'b1);
    send_item(CMD_FRAG, 1, 0, 16'h1001, 24'h0000ff, 8'd255, 1'b0);
    send_item(CMD_FRAG, 1, 0, 16'h1000, 24'h0000ff, 8'd255, 1'b0);

    // zero width: everything off the surface, loads too
    drain();
    set_config(0, 1, 1, 0, 0, 0, 0, 256);
    send_item(CMD_FRAG, 0, 0, 16'h0000, 24'h111111, 8'h11, 1'b0);
    send_item(CMD_LOAD, 0, 0, 16'h0000, '0, '0, 1'b0);

    // oversize width clamps, single row, depth writes masked
    drain();
    set_config(1, 0, 1, 0, 0, 0, 511, 1);
    send_item(CMD_FRAG, 255, 0, 16'h00ff, 24'h222222, 8'h22, 1'b0);
    send_item(CMD_FRAG, 255, 0, 16'h0000, 24'h333333, 8'h33, 1'b0);
    send_item(CMD_FRAG, 0, 1, 16'h0000, 24'h444444, 8'h44, 1'b0);

    // single column, early mode without depth test does nothing to depth
    drain();
    set_config(0, 1, 0, 0, 0, 0, 1, 256);
    send_item(CMD_FRAG, 1, 0, 16'h0000, 24'h555555, 8'h55, 1'b0);
    send_item(CMD_FRAG, 0, 0, 16'hffff, 24'h666666, 8'h66, 1'b0);

    // ---- random phases, each under a fresh configuration ----
    for (int ph = 0; ph < PHASES; ph++) begin
      // sender idles lightly and receiver heavily, then swapped, then none
      send_idle_pct = (ph < 4) ? 13 : (ph < 8) ? 83 : 0;
      recv_idle_pct = (ph < 4) ? 83 : (ph < 8) ? 13 : 0;
      drain();
      random_config();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming, so the block backs up
        if (ph == 1 && n == 20) hold_req = 1'b1;
        // sender pause mid-phase until everything is back
        if (ph == 9 && n == ITEMS_PER_PHASE / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("depth_alpha_fragment_test_top_tb: done, clean");
    else
      $display("depth_alpha_fragment_test_top_tb: done, errors");
    $finish;
  end

endmodule
